// ===== sv/mrh_pkg.sv =====
// ----------------------------------------------------------------------------
// mrh_pkg: shared definitions of the Mersenne-61 rolling hash
// Request and status codes, widths and modular helpers for P = 2^61 - 1.
// ----------------------------------------------------------------------------
`default_nettype none

package mrh_pkg;

   localparam int HASH_W = 61;
   localparam int POS_W  = 12;
   localparam int DEPTH  = 4096;

   localparam logic [POS_W-1:0]  MAX_LEN    = 12'd4095;
   localparam logic [HASH_W-1:0] MOD_P      = 61'h1fff_ffff_ffff_ffff;
   localparam logic [HASH_W-1:0] BASE_RESET = 61'd257;

   localparam logic [2:0] REQ_APPEND = 3'd0;
   localparam logic [2:0] REQ_CLEAR  = 3'd1;
   localparam logic [2:0] REQ_GET    = 3'd2;
   localparam logic [2:0] REQ_JOIN   = 3'd3;
   localparam logic [2:0] REQ_LCP    = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_RANGE = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FETCH = 8'b0000_0010,
      ST_LOAD  = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_RED   = 8'b0001_0000,
      ST_POST  = 8'b0010_0000,
      ST_LCP   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   // fold a value below 2^62 into [0, P)
   function automatic logic [HASH_W-1:0] mod62(input logic [HASH_W:0] s);
      logic [HASH_W:0] t;
      t = {1'b0, s[HASH_W-1:0]} + {{HASH_W{1'b0}}, s[HASH_W]};
      if (t >= {1'b0, MOD_P}) begin
         t = t - {1'b0, MOD_P};
      end
      return t[HASH_W-1:0];
   endfunction

   // the value P itself stands for zero
   function automatic logic [HASH_W-1:0] fix_p(input logic [HASH_W-1:0] v);
      return (v == MOD_P) ? '0 : v;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mersenne61_rolling_hash.sv =====
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash: prefix hashes modulo 2^61-1 over a byte store
// Appends bytes, answers substring hashes, joins hashes and binary-searches
// the longest common prefix, all through one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | type, byte, ranges, hashes
//  rsp     | out       | rsp_valid/rsp_ready  | hash, prefix len, len, status
//  csr     | in        | csr_wr_en            | hash base, 61 bits
//
// One modular multiply runs partial products in ST_MUL, then reduce (ST_RED)
// and post (ST_POST). An append takes two multiplies, substring hash and join
// one, LCP two per search step, up to 12 steps; clear and errors go straight
// to ST_OUT. The one multiplier and single table read ports serialise items.
// Reset is synchronous; table entry zero is supplied as a constant, no sweep.
// req_ready is low while an item is worked; a waiting result stalls only the
// final hand-off into the output register.
`default_nettype none

module mersenne61_rolling_hash (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_type,
   input  wire logic [7:0]                    req_char_value,
   input  wire logic [mrh_pkg::POS_W-1:0]     req_left_a,
   input  wire logic [mrh_pkg::POS_W-1:0]     req_right_a,
   input  wire logic [mrh_pkg::POS_W-1:0]     req_left_b,
   input  wire logic [mrh_pkg::POS_W-1:0]     req_right_b,
   input  wire logic [mrh_pkg::HASH_W-1:0]    req_hash_first,
   input  wire logic [mrh_pkg::HASH_W-1:0]    req_hash_second,
   input  wire logic [mrh_pkg::POS_W-1:0]     req_second_len,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [mrh_pkg::HASH_W-1:0]         rsp_hash_value,
   output logic [mrh_pkg::POS_W-1:0]          rsp_prefix_len,
   output logic [mrh_pkg::POS_W-1:0]          rsp_stored_len,
   output logic [1:0]                         rsp_status,
   input  wire logic                          csr_wr_en,
   input  wire logic [mrh_pkg::HASH_W-1:0]    csr_wr_data
);

   mrh_pkg::state_type state_ff, state_in;
   logic [2:0]   rq_ff, rq_in;
   logic         phase_ff, phase_in;
   logic [11:0]  len_ff, len_in;
   logic [60:0]  base_ff;
   logic [11:0]  la_ff, la_in, lb_ff, lb_in, r_ff, r_in;
   logic [11:0]  ph_addr_ff, ph_addr_in, bp_addr_ff, bp_addr_in;
   logic [7:0]   ch_ff, ch_in;
   logic [60:0]  h1_ff, h1_in, h2_ff, h2_in;
   logic [60:0]  a_ff, a_in, b_ff, b_in;
   logic [2:0]   mc_ff, mc_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   sh_ff, sh_in;
   logic [121:0] acc_ff, acc_in;
   logic [60:0]  prod_ff, prod_in;
   logic [60:0]  hash_a_ff, hash_a_in;
   logic [12:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [11:0]  mid_ff, mid_in;
   logic [60:0]  res_hash_ff, res_hash_in;
   logic [11:0]  res_plen_ff, res_plen_in;
   logic [1:0]   res_status_ff, res_status_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [60:0]  out_hash_ff, out_hash_in;
   logic [11:0]  out_plen_ff, out_plen_in, out_len_ff, out_len_in;
   logic [1:0]   out_status_ff, out_status_in;

   logic [60:0]  ph_mem [mrh_pkg::DEPTH];
   logic [60:0]  bp_mem [mrh_pkg::DEPTH];
   logic [60:0]  ph_rd_ff, bp_rd_ff;
   logic         ph_zero_ff, bp_zero_ff;
   logic         ph_we, bp_we;
   logic [60:0]  ph_wd, bp_wd;
   logic [11:0]  wr_addr;

   logic [60:0]  ph_data, bp_data, sub_hash;
   logic [31:0]  mul_x, mul_y;
   logic [121:0] pp_ext;
   logic         ok_a, ok_b;
   logic [11:0]  da, db, dmin;
   logic [13:0]  lohi_sum;

   assign ph_data  = ph_zero_ff ? '0 : ph_rd_ff;
   assign bp_data  = bp_zero_ff ? 61'd1 : bp_rd_ff;
   assign sub_hash = mrh_pkg::mod62({1'b0, ph_data} + {1'b0, mrh_pkg::MOD_P}
                                    - {1'b0, prod_ff});
   assign wr_addr  = len_ff + 12'd1;

   assign ok_a = (req_left_a <= req_right_a) && (req_right_a <= len_ff);
   assign ok_b = (req_left_b <= req_right_b) && (req_right_b <= len_ff);
   assign da   = req_right_a - req_left_a;
   assign db   = req_right_b - req_left_b;
   assign dmin = (da < db) ? da : db;
   assign lohi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   // partial product select: low/high halves of both operands
   assign mul_x  = mc_ff[1] ? {3'b000, a_ff[60:32]} : a_ff[31:0];
   assign mul_y  = mc_ff[0] ? {3'b000, b_ff[60:32]} : b_ff[31:0];
   assign pp_ext = {58'd0, pp_ff};

   assign req_ready      = (state_ff == mrh_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = out_hash_ff;
   assign rsp_prefix_len = out_plen_ff;
   assign rsp_stored_len = out_len_ff;
   assign rsp_status     = out_status_ff;

   always_comb begin
      state_in = state_ff;   rq_in = rq_ff;       phase_in = phase_ff;
      len_in = len_ff;       la_in = la_ff;       lb_in = lb_ff;
      r_in = r_ff;           ph_addr_in = ph_addr_ff;
      bp_addr_in = bp_addr_ff;
      ch_in = ch_ff;         h1_in = h1_ff;       h2_in = h2_ff;
      a_in = a_ff;           b_in = b_ff;         mc_in = mc_ff;
      pp_in = pp_ff;         sh_in = sh_ff;       acc_in = acc_ff;
      prod_in = prod_ff;     hash_a_in = hash_a_ff;
      lo_in = lo_ff;         hi_in = hi_ff;       mid_in = mid_ff;
      res_hash_in = res_hash_ff;  res_plen_in = res_plen_ff;
      res_status_in = res_status_ff;
      out_hash_in = out_hash_ff;  out_plen_in = out_plen_ff;
      out_len_in = out_len_ff;    out_status_in = out_status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ph_we = 1'b0;  bp_we = 1'b0;  ph_wd = prod_ff;  bp_wd = prod_ff;

      case (state_ff)
         mrh_pkg::ST_IDLE: begin
            if (req_valid) begin
               rq_in = req_type;      ch_in = req_char_value;
               la_in = req_left_a;    lb_in = req_left_b;
               h1_in = mrh_pkg::fix_p(req_hash_first);
               h2_in = mrh_pkg::fix_p(req_hash_second);
               res_hash_in = '0;      res_plen_in = '0;
               res_status_in = mrh_pkg::STAT_OK;
               phase_in = 1'b0;
               state_in = mrh_pkg::ST_OUT;
               case (req_type)
                  mrh_pkg::REQ_APPEND: begin
                     if (len_ff >= mrh_pkg::MAX_LEN) begin
                        res_status_in = mrh_pkg::STAT_FULL;
                     end else begin
                        ph_addr_in = len_ff;  bp_addr_in = len_ff;
                        state_in = mrh_pkg::ST_FETCH;
                     end
                  end
                  mrh_pkg::REQ_CLEAR: begin
                     len_in = '0;
                  end
                  mrh_pkg::REQ_GET: begin
                     if (ok_a) begin
                        ph_addr_in = req_left_a;  bp_addr_in = da;
                        r_in = req_right_a;
                        state_in = mrh_pkg::ST_FETCH;
                     end else begin
                        res_status_in = mrh_pkg::STAT_RANGE;
                     end
                  end
                  mrh_pkg::REQ_JOIN: begin
                     if (req_second_len <= len_ff) begin
                        bp_addr_in = req_second_len;
                        state_in = mrh_pkg::ST_FETCH;
                     end else begin
                        res_status_in = mrh_pkg::STAT_RANGE;
                     end
                  end
                  mrh_pkg::REQ_LCP: begin
                     if (ok_a && ok_b) begin
                        lo_in = '0;
                        hi_in = {1'b0, dmin} + 13'd1;
                        state_in = mrh_pkg::ST_LCP;
                     end else begin
                        res_status_in = mrh_pkg::STAT_RANGE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mrh_pkg::ST_FETCH: begin
            state_in = mrh_pkg::ST_LOAD;
         end
         mrh_pkg::ST_LOAD: begin
            case (rq_ff)
               mrh_pkg::REQ_APPEND: begin
                  a_in = bp_data;  b_in = base_ff;
               end
               mrh_pkg::REQ_JOIN: begin
                  a_in = h1_ff;    b_in = bp_data;
               end
               default: begin
                  // fetch the right-end prefix while the multiply runs
                  a_in = ph_data;  b_in = bp_data;  ph_addr_in = r_ff;
               end
            endcase
            mc_in = '0;
            state_in = mrh_pkg::ST_MUL;
         end
         mrh_pkg::ST_MUL: begin
            if (mc_ff == 3'd0) begin
               acc_in = '0;
            end else begin
               case (sh_ff)
                  2'd0:    acc_in = acc_ff + pp_ext;
                  2'd1:    acc_in = acc_ff + (pp_ext << 32);
                  default: acc_in = acc_ff + (pp_ext << 64);
               endcase
            end
            if (mc_ff != 3'd4) begin
               pp_in = {32'd0, mul_x} * {32'd0, mul_y};
               sh_in = {1'b0, mc_ff[1]} + {1'b0, mc_ff[0]};
               mc_in = mc_ff + 3'd1;
            end else begin
               state_in = mrh_pkg::ST_RED;
            end
         end
         mrh_pkg::ST_RED: begin
            prod_in = mrh_pkg::mod62({1'b0, acc_ff[121:61]} + {1'b0, acc_ff[60:0]});
            state_in = mrh_pkg::ST_POST;
         end
         mrh_pkg::ST_POST: begin
            case (rq_ff)
               mrh_pkg::REQ_APPEND: begin
                  if (!phase_ff) begin
                     bp_we = 1'b1;
                     a_in = ph_data;  b_in = base_ff;  mc_in = '0;
                     phase_in = 1'b1;
                     state_in = mrh_pkg::ST_MUL;
                  end else begin
                     ph_we = 1'b1;
                     ph_wd = mrh_pkg::mod62({1'b0, prod_ff} + {54'd0, ch_ff});
                     len_in = wr_addr;
                     state_in = mrh_pkg::ST_OUT;
                  end
               end
               mrh_pkg::REQ_JOIN: begin
                  res_hash_in = mrh_pkg::mod62({1'b0, prod_ff} + {1'b0, h2_ff});
                  state_in = mrh_pkg::ST_OUT;
               end
               mrh_pkg::REQ_GET: begin
                  res_hash_in = sub_hash;
                  state_in = mrh_pkg::ST_OUT;
               end
               default: begin
                  if (!phase_ff) begin
                     hash_a_in = sub_hash;
                     ph_addr_in = lb_ff;  bp_addr_in = mid_ff;
                     r_in = lb_ff + mid_ff;
                     phase_in = 1'b1;
                     state_in = mrh_pkg::ST_FETCH;
                  end else begin
                     if (sub_hash == hash_a_ff) begin
                        lo_in = {1'b0, mid_ff};
                     end else begin
                        hi_in = {1'b0, mid_ff};
                     end
                     state_in = mrh_pkg::ST_LCP;
                  end
               end
            endcase
         end
         mrh_pkg::ST_LCP: begin
            if ((hi_ff - lo_ff) > 13'd1) begin
               mid_in = lohi_sum[12:1];
               ph_addr_in = la_ff;  bp_addr_in = lohi_sum[12:1];
               r_in = la_ff + lohi_sum[12:1];
               phase_in = 1'b0;
               state_in = mrh_pkg::ST_FETCH;
            end else begin
               res_plen_in = lo_ff[11:0];
               state_in = mrh_pkg::ST_OUT;
            end
         end
         mrh_pkg::ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_hash_in = res_hash_ff;   out_plen_in = res_plen_ff;
               out_len_in = len_ff;         out_status_in = res_status_ff;
               rsp_valid_in = 1'b1;
               state_in = mrh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mrh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mrh_pkg::ST_IDLE;
         len_ff       <= '0;
         base_ff      <= mrh_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         mc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         mc_ff        <= mc_in;
         // base only changes while the store is empty
         if (csr_wr_en && (len_ff == '0)) begin
            base_ff <= mrh_pkg::fix_p(csr_wr_data);
         end
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= rq_in;          la_ff <= la_in;        lb_ff <= lb_in;
      r_ff <= r_in;            ph_addr_ff <= ph_addr_in;
      bp_addr_ff <= bp_addr_in;
      ch_ff <= ch_in;          h1_ff <= h1_in;        h2_ff <= h2_in;
      a_ff <= a_in;            b_ff <= b_in;          pp_ff <= pp_in;
      sh_ff <= sh_in;          acc_ff <= acc_in;      prod_ff <= prod_in;
      hash_a_ff <= hash_a_in;  lo_ff <= lo_in;        hi_ff <= hi_in;
      mid_ff <= mid_in;
      res_hash_ff <= res_hash_in;  res_plen_ff <= res_plen_in;
      res_status_ff <= res_status_in;
      out_hash_ff <= out_hash_in;  out_plen_ff <= out_plen_in;
      out_len_ff <= out_len_in;    out_status_ff <= out_status_in;
   end

   // table memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (ph_we) begin
         ph_mem[wr_addr] <= ph_wd;
      end
      ph_rd_ff   <= ph_mem[ph_addr_ff];
      ph_zero_ff <= (ph_addr_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (bp_we) begin
         bp_mem[wr_addr] <= bp_wd;
      end
      bp_rd_ff   <= bp_mem[bp_addr_ff];
      bp_zero_ff <= (bp_addr_ff == '0);
   end

`ifndef SYNTH
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= mrh_pkg::MAX_LEN) else $error("stored length beyond limit");

   a_mc_bound: assert property (@(posedge clock) disable iff (reset)
      mc_ff <= 3'd4) else $error("multiply step counter out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_type != mrh_pkg::REQ_CLEAR)) |=> !req_ready)
      else $error("ready stayed high after accepting an item");

   a_prod_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrh_pkg::ST_POST) |-> (prod_ff < mrh_pkg::MOD_P))
      else $error("product not reduced");

   a_lcp_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrh_pkg::ST_LCP) |-> (lo_ff < hi_ff))
      else $error("prefix search bounds crossed");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Mersenne-61 rolling hash block
// Walks a directed table of requests, then random phases of appends, substring
// hashes, joins and prefix searches under several hash bases. Every response is
// checked field by field against a directed expected value or an in-bench model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [mrh_pkg::POS_W-1:0]  pos_type;
   typedef logic [mrh_pkg::HASH_W-1:0] hash_type;
   typedef logic [mrh_pkg::HASH_W:0]   wide_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      pos_type    la, ra, lb, rb;
      hash_type   h1, h2;
      pos_type    l2;
   } hash_req_type;

   typedef struct packed {
      hash_type   hv;
      pos_type    plen;
      pos_type    slen;
      logic [1:0] st;
   } hash_rsp_type;

   typedef struct {
      hash_req_type r;
      bit           typed;
      hash_rsp_type want;
   } dir_row_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_wr_en;
   logic [2:0] req_type;
   logic [7:0] req_char_value;
   pos_type    req_left_a, req_right_a, req_left_b, req_right_b, req_second_len;
   hash_type   req_hash_first, req_hash_second, csr_wr_data;
   hash_type   rsp_hash_value;
   pos_type    rsp_prefix_len, rsp_stored_len;
   logic [1:0] rsp_status;

   mersenne61_rolling_hash dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_char_value(req_char_value),
      .req_left_a(req_left_a), .req_right_a(req_right_a),
      .req_left_b(req_left_b), .req_right_b(req_right_b),
      .req_hash_first(req_hash_first), .req_hash_second(req_hash_second),
      .req_second_len(req_second_len),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hash_value(rsp_hash_value), .rsp_prefix_len(rsp_prefix_len),
      .rsp_stored_len(rsp_stored_len), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // model state
   hash_type    pfx_hash [0:mrh_pkg::DEPTH-1];
   hash_type    pow_tab  [0:mrh_pkg::DEPTH-1];
   int unsigned str_len;
   hash_type    base_q;

   hash_rsp_type pending_rsp [$];
   int  errors, n_items, n_rsp, n_lcp_hits;
   bit  burst;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("timeout at %0t", $realtime);
      $display("== FAIL ==");
      $finish;
   end

   function automatic hash_type fold(input wide_type s);
      if (s >= {1'b0, mrh_pkg::MOD_P}) s = s - {1'b0, mrh_pkg::MOD_P};
      if (s >= {1'b0, mrh_pkg::MOD_P}) s = s - {1'b0, mrh_pkg::MOD_P};
      return s[mrh_pkg::HASH_W-1:0];
   endfunction

   function automatic hash_type mulmod(input hash_type a, input hash_type b);
      logic [2*mrh_pkg::HASH_W-1:0] p;
      p = (2*mrh_pkg::HASH_W)'(a) * (2*mrh_pkg::HASH_W)'(b);
      return fold({1'b0, p[2*mrh_pkg::HASH_W-1:mrh_pkg::HASH_W]}
                  + {1'b0, p[mrh_pkg::HASH_W-1:0]});
   endfunction

   function automatic hash_type span_hash(input int unsigned l, input int unsigned r);
      hash_type t;
      t = mulmod(pfx_hash[l], pow_tab[r - l]);
      return fold({1'b0, pfx_hash[r]} + {1'b0, mrh_pkg::MOD_P} - {1'b0, t});
   endfunction

   function automatic bit span_ok(input int unsigned l, input int unsigned r);
      return l <= r && r <= str_len;
   endfunction

   function automatic hash_rsp_type hash_predict(input hash_req_type q);
      hash_rsp_type o;
      hash_type a, b;
      int unsigned lo, hi, mid, da, db;
      o = '0;
      a = fold({1'b0, q.h1});
      b = fold({1'b0, q.h2});
      case (q.kind)
         mrh_pkg::REQ_APPEND: begin
            if (str_len >= mrh_pkg::MAX_LEN) o.st = mrh_pkg::STAT_FULL;
            else begin
               pow_tab[str_len+1]  = mulmod(pow_tab[str_len], base_q);
               pfx_hash[str_len+1] = fold({1'b0, mulmod(pfx_hash[str_len], base_q)} + q.ch);
               str_len++;
            end
         end
         mrh_pkg::REQ_CLEAR: str_len = 0;
         mrh_pkg::REQ_GET: begin
            if (span_ok(q.la, q.ra)) o.hv = span_hash(q.la, q.ra);
            else o.st = mrh_pkg::STAT_RANGE;
         end
         mrh_pkg::REQ_JOIN: begin
            if (q.l2 <= str_len) o.hv = fold({1'b0, mulmod(a, pow_tab[q.l2])} + b);
            else o.st = mrh_pkg::STAT_RANGE;
         end
         mrh_pkg::REQ_LCP: begin
            if (span_ok(q.la, q.ra) && span_ok(q.lb, q.rb)) begin
               da = q.ra - q.la;
               db = q.rb - q.lb;
               lo = 0;
               hi = ((da < db) ? da : db) + 1;
               while (hi - lo > 1) begin
                  mid = (lo + hi) / 2;
                  if (span_hash(q.la, q.la + mid) == span_hash(q.lb, q.lb + mid)) lo = mid;
                  else hi = mid;
               end
               o.plen = lo[mrh_pkg::POS_W-1:0];
               if (lo > 0) n_lcp_hits++;
            end else o.st = mrh_pkg::STAT_RANGE;
         end
         default: ;
      endcase
      o.slen = str_len[mrh_pkg::POS_W-1:0];
      return o;
   endfunction

   // hold valid and payload until the item is taken
   task automatic send(input hash_req_type q, input bit typed, input hash_rsp_type want);
      int gap;
      hash_rsp_type p;
      gap = burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= q.kind;
      req_char_value  <= q.ch;
      req_left_a      <= q.la;
      req_right_a     <= q.ra;
      req_left_b      <= q.lb;
      req_right_b     <= q.rb;
      req_hash_first  <= q.h1;
      req_hash_second <= q.h2;
      req_second_len  <= q.l2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = hash_predict(q);
      pending_rsp.push_back(typed ? want : p);
      n_items++;
   endtask

   task automatic send_req(input hash_req_type q);
      send(q, 1'b0, '0);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_base(input hash_type v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (str_len == 0) base_q = fold({1'b0, v});
   endtask

   function automatic hash_req_type mk(input logic [2:0] k, input logic [7:0] c,
                                       input int la, input int ra, input int lb, input int rb,
                                       input hash_type h1, input hash_type h2,
                                       input int l2);
      hash_req_type q;
      q.kind = k; q.ch = c;
      q.la = la[mrh_pkg::POS_W-1:0]; q.ra = ra[mrh_pkg::POS_W-1:0];
      q.lb = lb[mrh_pkg::POS_W-1:0]; q.rb = rb[mrh_pkg::POS_W-1:0];
      q.h1 = h1; q.h2 = h2; q.l2 = l2[mrh_pkg::POS_W-1:0];
      return q;
   endfunction

   function automatic dir_row_type row(input hash_req_type q, input bit typed,
                                       input hash_type hv, input int pl,
                                       input int sl, input logic [1:0] st);
      dir_row_type d;
      d.r = q; d.typed = typed;
      d.want.hv = hv; d.want.plen = pl[mrh_pkg::POS_W-1:0];
      d.want.slen = sl[mrh_pkg::POS_W-1:0]; d.want.st = st;
      return d;
   endfunction

   function automatic hash_type rand61();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[mrh_pkg::HASH_W-1:0];
   endfunction

   function automatic hash_req_type rand_query(input int alpha);
      hash_req_type q;
      logic [223:0] raw;
      int r, la, lb, n;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      q = raw[$bits(hash_req_type)-1:0];
      r = $urandom_range(0, 99);
      la = $urandom_range(0, str_len);
      lb = $urandom_range(0, str_len);
      q.la = pos_type'(la); q.ra = pos_type'($urandom_range(la, str_len));
      q.lb = pos_type'(lb); q.rb = pos_type'($urandom_range(lb, str_len));
      q.l2 = pos_type'($urandom_range(0, str_len));
      q.ch = (alpha >= 256) ? 8'($urandom_range(0, 255))
                            : 8'(8'h61 + $urandom_range(0, alpha - 1));
      if (r < 35) q.kind = mrh_pkg::REQ_APPEND;
      else if (r < 38) q.kind = mrh_pkg::REQ_CLEAR;
      else if (r < 58) q.kind = mrh_pkg::REQ_GET;
      else if (r < 72) begin
         q.kind = mrh_pkg::REQ_JOIN;
         if ($urandom_range(0, 1) && str_len > 0) begin
            n = $urandom_range(0, str_len);
            q.h1 = pfx_hash[n];
            q.h2 = pfx_hash[$urandom_range(0, str_len)];
         end
      end else if (r < 92) begin
         q.kind = mrh_pkg::REQ_LCP;
         // aim the second span at an equal stretch now and then
         if ($urandom_range(0, 2) == 0) begin q.lb = q.la; q.rb = q.ra; end
      end else if (r < 96) begin
         q.kind = 3'($urandom_range(0, 7));
      end else begin
         // broken ranges
         q.kind = $urandom_range(0, 1) ? mrh_pkg::REQ_LCP : mrh_pkg::REQ_GET;
         q.ra = pos_type'($urandom); q.la = pos_type'($urandom);
      end
      return q;
   endfunction

   always @(posedge clock) begin
      hash_rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing expected: hv=%h", $realtime, rsp_hash_value);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_hash_value !== w.hv) begin
               $display("%0t: hash_value exp %h got %h", $realtime, w.hv, rsp_hash_value);
               errors++;
            end
            if (rsp_prefix_len !== w.plen) begin
               $display("%0t: prefix_len exp %0d got %0d", $realtime, w.plen, rsp_prefix_len);
               errors++;
            end
            if (rsp_stored_len !== w.slen) begin
               $display("%0t: stored_len exp %0d got %0d", $realtime, w.slen, rsp_stored_len);
               errors++;
            end
            if (rsp_status !== w.st) begin
               $display("%0t: status exp %0d got %0d", $realtime, w.st, rsp_status);
               errors++;
            end
         end
      end
   end

   // response side back-pressure
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = burst ? 0 : $urandom_range(0, 5);
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      dir_row_type dir [$];
      hash_type bases [5];
      int alpha, k;
      hash_req_type q;
      reset = 1'b1; req_valid = 1'b0; csr_wr_en = 1'b0; csr_wr_data = '0;
      req_type = '0; req_char_value = '0; req_left_a = '0; req_right_a = '0;
      req_left_b = '0; req_right_b = '0; req_hash_first = '0; req_hash_second = '0;
      req_second_len = '0;
      errors = 0; n_items = 0; n_rsp = 0; n_lcp_hits = 0; burst = 0;
      for (int i = 0; i < mrh_pkg::DEPTH; i++) begin pfx_hash[i] = '0; pow_tab[i] = '0; end
      pow_tab[0] = 1; str_len = 0; base_q = mrh_pkg::BASE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, state right after reset
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 0, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 0, 1, 0, 0, 0, 0, 0),
                        1, 0, 0, 0, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_LCP, 0, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 0, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, mrh_pkg::MOD_P,
                           mrh_pkg::MOD_P, 0), 1, 0, 0, 0, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, 5, 7, 1),
                        1, 0, 0, 0, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_APPEND, 8'h00, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 1, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_APPEND, 8'hff, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 2, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_APPEND, 8'h00, 0, 0, 0, 0, 0, 0, 0),
                        0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_APPEND, 8'hff, 0, 0, 0, 0, 0, 0, 0),
                        0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 0, 4, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 1, 2, 0, 0, 0, 0, 0), 0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 2, 1, 0, 0, 0, 0, 0),
                        1, 0, 0, 4, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 0, 4095, 0, 0, 0, 0, 0),
                        1, 0, 0, 4, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_LCP, 0, 0, 4, 2, 4, 0, 0, 0), 0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_LCP, 0, 0, 2, 1, 3, 0, 0, 0), 0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_LCP, 0, 0, 2, 3, 2, 0, 0, 0),
                        1, 0, 0, 4, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_LCP, 0, 4095, 4095, 0, 1, 0, 0, 0),
                        1, 0, 0, 4, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, mrh_pkg::MOD_P - 1,
                           mrh_pkg::MOD_P - 1, 4), 0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, mrh_pkg::MOD_P, 3, 2),
                        0, 0, 0, 0, 0));
      dir.push_back(row(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, 1, 2, 4095),
                        1, 0, 0, 4, mrh_pkg::STAT_RANGE));
      dir.push_back(row(mk(3'd5, 8'hff, 0, 4, 0, 4, 1, 1, 1), 1, 0, 0, 4, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(3'd7, 8'h11, 0, 1, 0, 1, 1, 1, 1), 1, 0, 0, 4, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 0, mrh_pkg::STAT_OK));
      dir.push_back(row(mk(mrh_pkg::REQ_GET, 0, 0, 0, 0, 0, 0, 0, 0),
                        1, 0, 0, 0, mrh_pkg::STAT_OK));
      foreach (dir[i]) send(dir[i].r, dir[i].typed, dir[i].want);

      // long two-letter string, then spans over all of it
      write_base(61'd2);
      alpha = 2;
      for (int i = 0; i < 200; i++) begin
         burst = (i % 100) < 30;
         send_req(mk(mrh_pkg::REQ_APPEND, 8'(8'h61 + $urandom_range(0, alpha - 1)),
                     0, 0, 0, 0, 0, 0, 0));
      end
      burst = 0;
      send_req(mk(mrh_pkg::REQ_GET, 0, 0, 200, 0, 0, 0, 0, 0));
      send_req(mk(mrh_pkg::REQ_LCP, 0, 0, 200, 0, 200, 0, 0, 0));
      send_req(mk(mrh_pkg::REQ_LCP, 0, 0, 199, 1, 200, 0, 0, 0));
      send_req(mk(mrh_pkg::REQ_JOIN, 0, 0, 0, 0, 0, mrh_pkg::MOD_P - 1,
                  mrh_pkg::MOD_P - 1, 200));
      // ignored while the store holds bytes
      write_base(rand61());
      send_req(mk(mrh_pkg::REQ_GET, 0, 100, 150, 0, 0, 0, 0, 0));
      send_req(mk(mrh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));

      // random phases over several bases
      bases[0] = mrh_pkg::MOD_P - 1; bases[1] = mrh_pkg::MOD_P; bases[2] = 61'd2;
      bases[3] = mrh_pkg::BASE_RESET; bases[4] = '1;
      for (int ph = 0; ph < 10; ph++) begin
         burst = 0;
         send_req(mk(mrh_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
         write_base(ph < 5 ? bases[ph] : rand61());
         if (ph == 6) write_base(rand61());
         k = $urandom_range(0, 3);
         alpha = (k == 0) ? 1 : (k == 1) ? 2 : (k == 2) ? 4 : 256;
         burst = (ph % 4) == 3;
         for (int i = 0; i < 64; i++) begin
            q = rand_query(alpha);
            send_req(q);
         end
      end
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d requests and %0d responses, a 200-byte span check and 10 bases",
               n_items, n_rsp);
      $display("%0d prefix searches found a nonzero common prefix", n_lcp_hits);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/mrh_pkg.sv
sv/mersenne61_rolling_hash.sv
dv/tb_top.sv
